@@ hdl/drld_pkg.sv @@
`default_nettype none
package drld_pkg;

   localparam int DATA_W  = 8;
   localparam int WORD_W  = 64;
   localparam int KIND_W  = 3;
   localparam int COUNT_W = 4;
   localparam int LANES   = WORD_W / DATA_W;

   localparam int QUEUE_DEPTH_DEF = 2;

   // result kinds
   localparam logic [KIND_W-1:0] KIND_RUN        = 3'd0;
   localparam logic [KIND_W-1:0] KIND_TERMINATOR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_EXHAUSTED  = 3'd2;
   localparam logic [KIND_W-1:0] KIND_BAD_SIZE   = 3'd3;
   localparam logic [KIND_W-1:0] KIND_TRUNCATED  = 3'd4;

   // job codes passed from front to back
   localparam logic [1:0] OP_RUN   = 2'd0;
   localparam logic [1:0] OP_STAT  = 2'd1;
   localparam logic [1:0] OP_CLEAR = 2'd2;

   typedef struct packed {
      logic [1:0]        op;
      logic [KIND_W-1:0] kind;
      logic              eol;
      logic [WORD_W-1:0] len;
      logic [WORD_W-1:0] off;
   } job_type;

   // sign-extend a little-endian field of cnt bytes from its top byte
   function automatic logic [WORD_W-1:0] sext_field(input logic [WORD_W-1:0] raw,
                                                    input logic [COUNT_W-1:0] cnt);
      logic [WORD_W-1:0] res;
      logic              sign;
      res  = raw;
      sign = 1'b0;
      for (int j = 0; j < LANES - 1; j++) begin
         if (cnt == COUNT_W'(j + 1)) begin
            sign = raw[DATA_W*j + DATA_W - 1];
         end
      end
      if (cnt != '0 && cnt < COUNT_W'(LANES)) begin
         for (int i = 0; i < LANES; i++) begin
            if (COUNT_W'(i) >= cnt) begin
               res[DATA_W*i +: DATA_W] = {DATA_W{sign}};
            end
         end
      end
      return res;
   endfunction

endpackage
`default_nettype wire

@@ hdl/drld_front.sv @@
`default_nettype none
module drld_front import drld_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              accept,
   input  wire logic [DATA_W-1:0] data_byte,
   input  wire logic              end_of_list,
   output logic                   push_valid,
   output job_type                push_job
);

   localparam logic [1:0] PH_HEADER = 2'd0;
   localparam logic [1:0] PH_LENGTH = 2'd1;
   localparam logic [1:0] PH_OFFSET = 2'd2;
   localparam logic [1:0] PH_DONE   = 2'd3;

   logic [1:0]         phase_ff, phase_in;
   logic [COUNT_W-1:0] len_bytes_ff, len_bytes_in;
   logic [COUNT_W-1:0] off_bytes_ff, off_bytes_in;
   logic [COUNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0]  len_acc_ff, len_acc_in;
   logic [WORD_W-1:0]  off_acc_ff, off_acc_in;

   logic [COUNT_W-1:0] hdr_len, hdr_off, cnt_next;
   logic [WORD_W-1:0]  len_merged, off_merged;

   assign hdr_len  = data_byte[3:0];
   assign hdr_off  = data_byte[7:4];
   assign cnt_next = cnt_ff + COUNT_W'(1);

   // counter stays below the field size, so its low bits pick the lane
   always_comb begin
      len_merged = len_acc_ff;
      off_merged = off_acc_ff;
      len_merged[DATA_W*cnt_ff[2:0] +: DATA_W] = data_byte;
      off_merged[DATA_W*cnt_ff[2:0] +: DATA_W] = data_byte;
   end

   always_comb begin
      phase_in     = phase_ff;
      len_bytes_in = len_bytes_ff;
      off_bytes_in = off_bytes_ff;
      cnt_in       = cnt_ff;
      len_acc_in   = len_acc_ff;
      off_acc_in   = off_acc_ff;
      push_valid   = 1'b0;
      push_job     = '{op: OP_STAT, kind: KIND_TERMINATOR, eol: end_of_list,
                       len: len_acc_ff, off: '0};
      if (accept) begin
         case (phase_ff)
            PH_HEADER: begin
               if (data_byte == '0) begin
                  push_valid    = 1'b1;
                  push_job.kind = KIND_TERMINATOR;
                  phase_in      = end_of_list ? PH_HEADER : PH_DONE;
               end else if (hdr_len == '0 || hdr_len > COUNT_W'(LANES)
                            || hdr_off > COUNT_W'(LANES)) begin
                  push_valid    = 1'b1;
                  push_job.kind = KIND_BAD_SIZE;
                  phase_in      = end_of_list ? PH_HEADER : PH_DONE;
               end else if (end_of_list) begin
                  push_valid    = 1'b1;
                  push_job.kind = KIND_TRUNCATED;
                  phase_in      = PH_HEADER;
               end else begin
                  len_bytes_in = hdr_len;
                  off_bytes_in = hdr_off;
                  cnt_in       = '0;
                  len_acc_in   = '0;
                  off_acc_in   = '0;
                  phase_in     = PH_LENGTH;
               end
            end
            PH_LENGTH: begin
               len_acc_in = len_merged;
               cnt_in     = cnt_next;
               if (cnt_next >= len_bytes_ff && off_bytes_ff == '0) begin
                  push_valid   = 1'b1;
                  push_job.op  = OP_RUN;
                  push_job.len = len_merged;
                  push_job.off = '0;
                  phase_in     = PH_HEADER;
               end else if (end_of_list) begin
                  push_valid    = 1'b1;
                  push_job.kind = KIND_TRUNCATED;
                  phase_in      = PH_HEADER;
               end else if (cnt_next >= len_bytes_ff) begin
                  cnt_in   = '0;
                  phase_in = PH_OFFSET;
               end
            end
            PH_OFFSET: begin
               off_acc_in = off_merged;
               cnt_in     = cnt_next;
               if (cnt_next >= off_bytes_ff) begin
                  push_valid   = 1'b1;
                  push_job.op  = OP_RUN;
                  push_job.off = sext_field(off_merged, off_bytes_ff);
                  phase_in     = PH_HEADER;
               end else if (end_of_list) begin
                  push_valid    = 1'b1;
                  push_job.kind = KIND_TRUNCATED;
                  phase_in      = PH_HEADER;
               end
            end
            default: begin
               // ignored bytes; end of list wipes the back's sums too
               if (end_of_list) begin
                  push_valid  = 1'b1;
                  push_job.op = OP_CLEAR;
                  phase_in    = PH_HEADER;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         len_bytes_ff <= '0;
         off_bytes_ff <= '0;
         cnt_ff       <= '0;
         len_acc_ff   <= '0;
         off_acc_ff   <= '0;
      end else begin
         phase_ff     <= phase_in;
         len_bytes_ff <= len_bytes_in;
         off_bytes_ff <= off_bytes_in;
         cnt_ff       <= cnt_in;
         len_acc_ff   <= len_acc_in;
         off_acc_ff   <= off_acc_in;
      end
   end

endmodule
`default_nettype wire

@@ hdl/drld_queue.sv @@
`default_nettype none
module drld_queue import drld_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire job_type push_job,
   input  wire logic    pop,
   output job_type      head,
   output logic         full,
   output logic         empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule
`default_nettype wire

@@ hdl/drld_back.sv @@
`default_nettype none
module drld_back import drld_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire job_type            head,
   input  wire logic               empty,
   output logic                    pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [KIND_W-1:0]       rsp_kind,
   output logic [WORD_W-1:0]       rsp_start_cluster,
   output logic [WORD_W-1:0]       rsp_run_clusters,
   output logic [WORD_W-1:0]       rsp_total_clusters,
   output logic                    rsp_last_of_list
);

   logic [WORD_W-1:0] pos_ff, pos_in;
   logic [WORD_W-1:0] tot_ff, tot_in;
   logic              second_ff, second_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic [KIND_W-1:0] kind_ff, kind_in;
   logic [WORD_W-1:0] start_ff, start_in;
   logic [WORD_W-1:0] run_ff, run_in;
   logic [WORD_W-1:0] total_ff, total_in;
   logic              last_ff, last_in;

   logic              go, emit, len_nz;
   logic [WORD_W-1:0] sum_pos, sum_tot;

   assign go      = !empty && (!rsp_valid_ff || rsp_ready);
   assign sum_pos = pos_ff + head.off;
   assign sum_tot = tot_ff + head.len;
   assign len_nz  = (head.len != '0);

   always_comb begin
      pos_in    = pos_ff;
      tot_in    = tot_ff;
      second_in = second_ff;
      pop       = 1'b0;
      emit      = 1'b0;
      kind_in   = head.kind;
      start_in  = pos_ff;
      run_in    = '0;
      total_in  = tot_ff;
      last_in   = 1'b1;
      if (go) begin
         case (head.op)
            OP_CLEAR: begin
               pos_in = '0;
               tot_in = '0;
               pop    = 1'b1;
            end
            OP_STAT: begin
               emit = 1'b1;
               pop  = 1'b1;
               if (head.eol) begin
                  pos_in = '0;
                  tot_in = '0;
               end
            end
            OP_RUN: begin
               if (second_ff) begin
                  // status after a run that closed the list
                  emit      = 1'b1;
                  kind_in   = KIND_EXHAUSTED;
                  pos_in    = '0;
                  tot_in    = '0;
                  second_in = 1'b0;
                  pop       = 1'b1;
               end else if (len_nz) begin
                  emit     = 1'b1;
                  kind_in  = KIND_RUN;
                  start_in = sum_pos;
                  run_in   = head.len;
                  total_in = sum_tot;
                  last_in  = 1'b0;
                  pos_in   = sum_pos;
                  tot_in   = sum_tot;
                  if (head.eol) begin
                     second_in = 1'b1;
                  end else begin
                     pop = 1'b1;
                  end
               end else begin
                  pos_in = sum_pos;
                  pop    = 1'b1;
                  if (head.eol) begin
                     emit     = 1'b1;
                     kind_in  = KIND_EXHAUSTED;
                     start_in = sum_pos;
                     pos_in   = '0;
                     tot_in   = '0;
                  end
               end
            end
            default: begin
               pop = 1'b1;
            end
         endcase
      end
   end

   always_comb begin
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         tot_ff       <= '0;
         second_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         tot_ff       <= tot_in;
         second_ff    <= second_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         kind_ff  <= kind_in;
         start_ff <= start_in;
         run_ff   <= run_in;
         total_ff <= total_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_kind           = kind_ff;
   assign rsp_start_cluster  = start_ff;
   assign rsp_run_clusters   = run_ff;
   assign rsp_total_clusters = total_ff;
   assign rsp_last_of_list   = last_ff;

endmodule
`default_nettype wire

@@ hdl/data_run_list_decoder_core.sv @@
// Run-list decoder: takes one run-list byte per cycle while the queue is not
// full; returns run records (start cluster, length, running total) and one
// status record per list. The front end assembles header, length and offset
// fields one accepted byte a cycle; each finished run or status becomes a job
// in a small queue (QUEUE_DEPTH entries) that the back end works off at one job
// per cycle unless the output register holds an untaken record, with one 64-bit
// position add and one 64-bit total add into that register. A byte that
// completes a run and ends the list yields two records and holds the back end
// for a second pass on its job, which the queue absorbs while the front keeps
// taking bytes until it is full; a job is queued, then its record registered.
`default_nettype none
module data_run_list_decoder_core import drld_pkg::*; #(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [DATA_W-1:0] req_data_byte,
   input  wire logic              req_end_of_list,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output logic [KIND_W-1:0]      rsp_kind,
   output logic [WORD_W-1:0]      rsp_start_cluster,
   output logic [WORD_W-1:0]      rsp_run_clusters,
   output logic [WORD_W-1:0]      rsp_total_clusters,
   output logic                   rsp_last_of_list
);

   logic    accept, push_valid, pop, full, empty;
   job_type push_job, head;

   assign req_ready = !full;
   assign accept    = req_valid && req_ready;

   drld_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (accept),
      .data_byte   (req_data_byte),
      .end_of_list (req_end_of_list),
      .push_valid  (push_valid),
      .push_job    (push_job)
   );

   drld_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push_valid),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .full     (full),
      .empty    (empty)
   );

   drld_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head               (head),
      .empty              (empty),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_start_cluster  (rsp_start_cluster),
      .rsp_run_clusters   (rsp_run_clusters),
      .rsp_total_clusters (rsp_total_clusters),
      .rsp_last_of_list   (rsp_last_of_list)
   );

endmodule
`default_nettype wire

@@ hdl/drld_checker.sv @@
`default_nettype none
module drld_checker import drld_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [KIND_W-1:0] rsp_kind,
   input wire logic [WORD_W-1:0] rsp_start_cluster,
   input wire logic [WORD_W-1:0] rsp_run_clusters,
   input wire logic [WORD_W-1:0] rsp_total_clusters,
   input wire logic              rsp_last_of_list
);

   // a result beat not taken stays offered with the same payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)
         && $stable(rsp_start_cluster) && $stable(rsp_run_clusters)
         && $stable(rsp_total_clusters) && $stable(rsp_last_of_list))
      else $error("result beat dropped or changed while stalled");

   // run records are never empty and never close a list
   a_run_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> !rsp_last_of_list && rsp_run_clusters != '0)
      else $error("malformed run record");

   // status records carry no length and close the list
   a_status_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_RUN |-> rsp_last_of_list && rsp_run_clusters == '0)
      else $error("malformed status record");

   // nothing is offered right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered out of reset");

endmodule

bind data_run_list_decoder_core drld_checker u_drld_checker (.*);
`default_nettype wire

@@ bench/testbench.sv @@
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import drld_pkg::*;

   typedef enum logic [1:0] {SEEK_HEADER, TAKE_LENGTH, TAKE_OFFSET, SKIP_REST} dec_phase_type;

   typedef struct packed {
      logic [DATA_W-1:0] value;
      logic              eol;
   } list_byte_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [WORD_W-1:0] start_cl;
      logic [WORD_W-1:0] length_cl;
      logic [WORD_W-1:0] total_cl;
      logic              last_flag;
   } run_rec_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   logic [DATA_W-1:0] req_data_byte = '0;
   logic              req_end_of_list = 1'b0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [WORD_W-1:0] rsp_start_cluster;
   logic [WORD_W-1:0] rsp_run_clusters;
   logic [WORD_W-1:0] rsp_total_clusters;
   logic              rsp_last_of_list;

   list_byte_type byte_feed[$];
   run_rec_type   pending_records[$];
   list_byte_type next_byte;
   run_rec_type   want;

   int accepted = 0;
   int total_items = 0;
   int hold_mark = 0;
   int hold_left = 0;
   bit hold_done = 1'b0;
   int errors = 0;

   // decoder state mirrored by the predictor
   dec_phase_type      dec_phase = SEEK_HEADER;
   logic [3:0]         len_count = '0;
   logic [3:0]         off_count = '0;
   logic [3:0]         field_idx = '0;
   logic [WORD_W-1:0]  len_acc = '0;
   logic [WORD_W-1:0]  off_acc = '0;
   logic [WORD_W-1:0]  position = '0;
   logic [WORD_W-1:0]  total_len = '0;

   data_run_list_decoder_core uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_byte      (req_data_byte),
      .req_end_of_list    (req_end_of_list),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_kind           (rsp_kind),
      .rsp_start_cluster  (rsp_start_cluster),
      .rsp_run_clusters   (rsp_run_clusters),
      .rsp_total_clusters (rsp_total_clusters),
      .rsp_last_of_list   (rsp_last_of_list)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   task automatic flag_mismatch(input string what);
      if (errors < 40) begin
         $display("ERROR @%0t: %s", $realtime, what);
      end
      errors++;
   endtask

   task automatic restart_list();
      dec_phase = SEEK_HEADER;
      len_count = '0;
      off_count = '0;
      field_idx = '0;
      len_acc   = '0;
      off_acc   = '0;
      position  = '0;
      total_len = '0;
   endtask

   task automatic post_status(input logic [KIND_W-1:0] k, input logic eol);
      run_rec_type rec;
      rec = '{k, position, WORD_W'(0), total_len, 1'b1};
      pending_records.insert(pending_records.size(), rec);
      if (eol) begin
         restart_list();
      end else begin
         dec_phase = SKIP_REST;
      end
   endtask

   task automatic close_run(input logic eol);
      logic [WORD_W-1:0] delta;
      int                nb;
      run_rec_type       rec;
      delta = off_acc;
      nb    = int'(off_count);
      // short offsets are signed by their top byte
      if (nb >= 1 && nb < LANES && delta[8*nb-1]) begin
         delta = delta | ({WORD_W{1'b1}} << (8*nb));
      end
      position = position + delta;
      if (len_acc != '0) begin
         total_len = total_len + len_acc;
         rec = '{KIND_RUN, position, len_acc, total_len, 1'b0};
         pending_records.insert(pending_records.size(), rec);
      end
      dec_phase = SEEK_HEADER;
      if (eol) begin
         post_status(KIND_EXHAUSTED, 1'b1);
      end
   endtask

   task automatic decode_byte(input logic [DATA_W-1:0] b, input logic eol);
      logic [3:0] lc;
      logic [3:0] oc;
      lc = b[3:0];
      oc = b[7:4];
      case (dec_phase)
         SEEK_HEADER: begin
            if (b == 8'h00) begin
               post_status(KIND_TERMINATOR, eol);
            end else if (lc == 0 || lc > LANES || oc > LANES) begin
               post_status(KIND_BAD_SIZE, eol);
            end else if (eol) begin
               post_status(KIND_TRUNCATED, 1'b1);
            end else begin
               len_count = lc;
               off_count = oc;
               field_idx = '0;
               len_acc   = '0;
               off_acc   = '0;
               dec_phase = TAKE_LENGTH;
            end
         end
         TAKE_LENGTH: begin
            if (field_idx < LANES) begin
               len_acc = len_acc | (WORD_W'(b) << (8*int'(field_idx)));
            end
            field_idx++;
            if (field_idx >= len_count && off_count == 0) begin
               close_run(eol);
            end else begin
               if (field_idx >= len_count) begin
                  field_idx = '0;
                  dec_phase = TAKE_OFFSET;
               end
               if (eol) begin
                  post_status(KIND_TRUNCATED, 1'b1);
               end
            end
         end
         TAKE_OFFSET: begin
            if (field_idx < LANES) begin
               off_acc = off_acc | (WORD_W'(b) << (8*int'(field_idx)));
            end
            field_idx++;
            if (field_idx >= off_count) begin
               close_run(eol);
            end else if (eol) begin
               post_status(KIND_TRUNCATED, 1'b1);
            end
         end
         default: begin
            if (eol) begin
               restart_list();
            end
         end
      endcase
   endtask

   function automatic int load_stage();
      int s;
      if (accepted * 3 < total_items) begin
         s = 0;
      end else if (accepted * 3 < 2 * total_items) begin
         s = 1;
      end else begin
         s = 2;
      end
      return s;
   endfunction

   function automatic int sender_idle_pct();
      int s;
      s = load_stage();
      return (s == 0) ? 36 : (s == 1) ? 53 : 0;
   endfunction

   function automatic int receiver_idle_pct();
      int s;
      s = load_stage();
      return (s == 0) ? 53 : (s == 1) ? 36 : 0;
   endfunction

   task automatic add_byte(input logic [DATA_W-1:0] value, input logic eol);
      list_byte_type item;
      item = '{value, eol};
      byte_feed.insert(byte_feed.size(), item);
   endtask

   // mostly short fields, now and then up to the full eight bytes
   function automatic int pick_count(input int lo);
      if ($urandom_range(3) == 0) begin
         return $urandom_range(LANES, lo);
      end
      return $urandom_range(3, lo);
   endfunction

   // well-formed list of runs, closed by eol, a terminator, or cut short
   task automatic add_list();
      int runs;
      int ending;
      int lc;
      int oc;
      int sent;
      bit zero_len;
      bit last;
      bit cut_short;
      runs      = $urandom_range(5);
      ending    = (runs == 0) ? 60 : $urandom_range(99);
      cut_short = (ending >= 85);
      for (int r = 0; r < runs; r++) begin
         last     = (r == runs - 1);
         lc       = pick_count(1);
         oc       = pick_count(0);
         zero_len = ($urandom_range(9) == 0);
         sent     = (last && cut_short) ? $urandom_range(lc + oc - 1) : lc + oc;
         add_byte({4'(oc), 4'(lc)}, last && cut_short && sent == 0);
         for (int i = 0; i < sent; i++) begin
            add_byte((i < lc && zero_len) ? 8'h00 : 8'($urandom),
                     last && (i == sent - 1) && (ending < 50 || cut_short));
         end
      end
      if (ending >= 50 && ending < 70) begin
         add_byte(8'h00, 1'b1);
      end else if (ending >= 70 && ending < 85) begin
         add_byte(8'h00, 1'b0);
         repeat ($urandom_range(4)) add_byte(8'($urandom), 1'b0);
         add_byte(8'($urandom), 1'b1);
      end
   endtask

   task automatic add_noise();
      repeat ($urandom_range(8, 1)) add_byte(8'($urandom), $urandom_range(3) == 0);
      add_byte(8'($urandom), 1'b1);
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            decode_byte(req_data_byte, req_end_of_list);
            accepted <= accepted + 1;
         end
         if (!req_valid || req_ready) begin
            if (byte_feed.size() != 0 && $urandom_range(99) >= sender_idle_pct()) begin
               next_byte = byte_feed.pop_front();
               req_valid       <= 1'b1;
               req_data_byte   <= next_byte.value;
               req_end_of_list <= next_byte.eol;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // one long receiver stall while the sender keeps pushing
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (!hold_done && accepted >= hold_mark) begin
         hold_left <= 300;
         hold_done <= 1'b1;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (pending_records.size() == 0) begin
               flag_mismatch($sformatf("unexpected record, kind %0d", rsp_kind));
            end else begin
               want = pending_records.pop_front();
               if (rsp_kind !== want.kind)
                  flag_mismatch($sformatf("kind %0d, want %0d", rsp_kind, want.kind));
               if (rsp_start_cluster !== want.start_cl)
                  flag_mismatch($sformatf("start_cluster %h, want %h",
                                          rsp_start_cluster, want.start_cl));
               if (rsp_run_clusters !== want.length_cl)
                  flag_mismatch($sformatf("run_clusters %h, want %h",
                                          rsp_run_clusters, want.length_cl));
               if (rsp_total_clusters !== want.total_cl)
                  flag_mismatch($sformatf("total_clusters %h, want %h",
                                          rsp_total_clusters, want.total_cl));
               if (rsp_last_of_list !== want.last_flag)
                  flag_mismatch($sformatf("last_of_list %b, want %b",
                                          rsp_last_of_list, want.last_flag));
            end
         end
         rsp_ready <= (hold_left == 0) && ($urandom_range(99) >= receiver_idle_pct());
      end
   end

   initial begin
      int drain;
      // lone terminator
      add_byte(8'h00, 1'b1);
      // one-byte length and negative one-byte offset
      add_byte(8'h11, 1'b0);
      add_byte(8'hFF, 1'b0);
      add_byte(8'h80, 1'b0);
      // zero-length run without offset
      add_byte(8'h01, 1'b0);
      add_byte(8'h00, 1'b0);
      // terminator mid-list, then skipped bytes up to the end-of-list beat
      add_byte(8'h00, 1'b0);
      add_byte(8'hAB, 1'b0);
      add_byte(8'h5A, 1'b1);
      // bad sizes: length count too big, length count zero, offset count too big
      add_byte(8'h09, 1'b1);
      add_byte(8'h10, 1'b0);
      add_byte(8'h00, 1'b1);
      add_byte(8'h91, 1'b1);
      // list ends on a header, then inside a length field
      add_byte(8'h21, 1'b1);
      add_byte(8'h12, 1'b0);
      add_byte(8'h34, 1'b1);
      // full eight-byte offset, list ends with the run: record plus exhausted
      add_byte(8'h81, 1'b0);
      add_byte(8'h7F, 1'b0);
      for (int i = 1; i < LANES; i++) begin
         add_byte(8'(i), 1'b0);
      end
      add_byte(8'hF0, 1'b1);

      while (byte_feed.size() < 1340) begin
         if ($urandom_range(99) < 85) begin
            add_list();
         end else begin
            add_noise();
         end
      end
      total_items = byte_feed.size();
      hold_mark   = (2 * total_items) / 3 + 30;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (accepted != total_items) @(posedge clock);
      drain = 0;
      while (pending_records.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      repeat (10) @(posedge clock);
      if (pending_records.size() != 0) begin
         flag_mismatch($sformatf("%0d records never arrived", pending_records.size()));
      end
      if (errors == 0) begin
         $display("data_run_list_decoder_core: match");
      end else begin
         $display("data_run_list_decoder_core: mismatch");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("data_run_list_decoder_core: mismatch");
      $finish;
   end

endmodule

@@ sim.f @@
hdl/drld_pkg.sv
hdl/drld_front.sv
hdl/drld_queue.sv
hdl/drld_back.sv
hdl/data_run_list_decoder_core.sv
hdl/drld_checker.sv
bench/testbench.sv
